/* sv/vsde_pkg.sv */
package vsde_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = 15;
    localparam int MAG_WIDTH   = 16;
    localparam int DIST_WIDTH  = 18;

    // shape_kind codes (code 3 behaves as the ellipsoid)
    localparam logic [1:0] SHAPE_ELLIPSOID = 2'd0;
    localparam logic [1:0] SHAPE_BOX       = 2'd1;
    localparam logic [1:0] SHAPE_ECYL      = 2'd2;

    // result_class codes
    localparam logic [1:0] CLASS_FINITE  = 2'd0;
    localparam logic [1:0] CLASS_POS_INF = 2'd1;
    localparam logic [1:0] CLASS_NEG_INF = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SHAPE_KIND  = 3'd0;
    localparam logic [2:0] REG_HALF_SIZE_X = 3'd1;
    localparam logic [2:0] REG_HALF_SIZE_Y = 3'd2;
    localparam logic [2:0] REG_HALF_SIZE_Z = 3'd3;
    localparam logic [2:0] REG_SMOOTHNESS  = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [DIST_WIDTH-1:0] distance;
        logic [1:0]                   result_class;
    } result_t;

    typedef struct packed {
        logic [1:0]            shape_kind;
        logic [SIZE_WIDTH-1:0] half_size_x;
        logic [SIZE_WIDTH-1:0] half_size_y;
        logic [SIZE_WIDTH-1:0] half_size_z;
        logic [SIZE_WIDTH-1:0] smoothness;
    } cfg_t;

    // Per-item context that rides along the arithmetic pipeline.
    typedef struct packed {
        logic                         is_box;
        logic                         is_cyl;
        logic                         origin;
        logic                         t_zero;
        logic [1:0]                   cls;
        logic signed [DIST_WIDTH-1:0] box_dist;
        logic signed [DIST_WIDTH-1:0] rz;
        logic [16:0]                  d;
        logic [MAG_WIDTH-1:0]         a_x;
        logic [MAG_WIDTH-1:0]         a_y;
        logic [MAG_WIDTH-1:0]         a_z;
    } side_t;

endpackage

/* sv/vsde_regs.sv */
module vsde_regs
    import vsde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic write_en;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (paddr[4:2])
                REG_SHAPE_KIND:  cfg_next.shape_kind  = pwdata[1:0];
                REG_HALF_SIZE_X: cfg_next.half_size_x = pwdata[SIZE_WIDTH-1:0];
                REG_HALF_SIZE_Y: cfg_next.half_size_y = pwdata[SIZE_WIDTH-1:0];
                REG_HALF_SIZE_Z: cfg_next.half_size_z = pwdata[SIZE_WIDTH-1:0];
                REG_SMOOTHNESS:  cfg_next.smoothness  = pwdata[SIZE_WIDTH-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape_kind  <= SHAPE_ELLIPSOID;
            cfg_reg.half_size_x <= 15'd16;
            cfg_reg.half_size_y <= 15'd16;
            cfg_reg.half_size_z <= 15'd16;
            cfg_reg.smoothness  <= 15'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SHAPE_KIND:  prdata = {30'd0, cfg_reg.shape_kind};
            REG_HALF_SIZE_X: prdata = {17'd0, cfg_reg.half_size_x};
            REG_HALF_SIZE_Y: prdata = {17'd0, cfg_reg.half_size_y};
            REG_HALF_SIZE_Z: prdata = {17'd0, cfg_reg.half_size_z};
            REG_SMOOTHNESS:  prdata = {17'd0, cfg_reg.smoothness};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* sv/vsde_sqrt.sv */
module vsde_sqrt
    import vsde_pkg::*;
#(
    parameter int IN_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [IN_WIDTH-1:0] radicand,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [IN_WIDTH/2:0] root,
    output side_t               out_side
);

    localparam int STEPS = (IN_WIDTH + 1) / 2;
    localparam int RW    = 2 * STEPS + 1;
    localparam int OW    = IN_WIDTH / 2 + 1;

    logic [RW-1:0]    x_reg  [STEPS];
    logic [RW-1:0]    r_reg  [STEPS];
    side_t            side_reg [STEPS];
    logic [STEPS-1:0] valid_reg;

    logic [RW-1:0] x_cur  [STEPS];
    logic [RW-1:0] r_cur  [STEPS];
    logic [RW-1:0] x_next [STEPS];
    logic [RW-1:0] r_next [STEPS];
    logic [RW-1:0] trial  [STEPS];

    logic          out_valid_reg;
    logic [OW-1:0] root_reg;
    side_t         out_side_reg;

    // One result bit per stage, restoring square root.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - k));
        if (k == 0)
        begin : g_first
            assign x_cur[k] = RW'(radicand);
            assign r_cur[k] = '0;
        end
        else
        begin : g_rest
            assign x_cur[k] = x_reg[k-1];
            assign r_cur[k] = r_reg[k-1];
        end
        assign trial[k]  = r_cur[k] + BIT;
        assign x_next[k] = (x_cur[k] >= trial[k]) ? x_cur[k] - trial[k] : x_cur[k];
        assign r_next[k] = (x_cur[k] >= trial[k]) ? (r_cur[k] >> 1) + BIT : r_cur[k] >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[STEPS-2:0], in_valid};
            out_valid_reg <= valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < STEPS; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < STEPS; k++)
        begin
            x_reg[k] <= x_next[k];
            r_reg[k] <= r_next[k];
        end
        // round half up: remainder above root
        root_reg     <= OW'(r_reg[STEPS-1] + RW'(x_reg[STEPS-1] > r_reg[STEPS-1]));
        out_side_reg <= side_reg[STEPS-1];
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign out_side  = out_side_reg;

endmodule

/* sv/vsde_div.sv */
module vsde_div
    import vsde_pkg::*;
#(
    parameter int NUM_WIDTH = 31,
    parameter int DEN_WIDTH = 17,
    parameter int LANES     = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] numer [LANES],
    input  logic [DEN_WIDTH-1:0] denom [LANES],
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [NUM_WIDTH-1:0] quot [LANES],
    output side_t                out_side
);

    logic [NUM_WIDTH-1:0] w_reg   [NUM_WIDTH][LANES];
    logic [DEN_WIDTH-1:0] rem_reg [NUM_WIDTH][LANES];
    logic [DEN_WIDTH-1:0] den_reg [NUM_WIDTH][LANES];
    side_t                side_reg [NUM_WIDTH];
    logic [NUM_WIDTH-1:0] valid_reg;

    logic [NUM_WIDTH-1:0] w_cur    [NUM_WIDTH][LANES];
    logic [DEN_WIDTH-1:0] rem_cur  [NUM_WIDTH][LANES];
    logic [DEN_WIDTH-1:0] den_cur  [NUM_WIDTH][LANES];
    logic [DEN_WIDTH:0]   trial    [NUM_WIDTH][LANES];
    logic                 ge       [NUM_WIDTH][LANES];
    logic [NUM_WIDTH-1:0] w_next   [NUM_WIDTH][LANES];
    logic [DEN_WIDTH-1:0] rem_next [NUM_WIDTH][LANES];

    // Shift one numerator bit into the remainder per stage; the quotient bit
    // shifts into the freed low end of the numerator word.
    for (genvar k = 0; k < NUM_WIDTH; k++)
    begin : g_step
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            if (k == 0)
            begin : g_first
                assign w_cur[k][l]   = numer[l];
                assign rem_cur[k][l] = '0;
                assign den_cur[k][l] = denom[l];
            end
            else
            begin : g_rest
                assign w_cur[k][l]   = w_reg[k-1][l];
                assign rem_cur[k][l] = rem_reg[k-1][l];
                assign den_cur[k][l] = den_reg[k-1][l];
            end
            assign trial[k][l]    = {rem_cur[k][l], w_cur[k][l][NUM_WIDTH-1]};
            assign ge[k][l]       = trial[k][l] >= {1'b0, den_cur[k][l]};
            assign rem_next[k][l] = ge[k][l]
                ? DEN_WIDTH'(trial[k][l] - {1'b0, den_cur[k][l]})
                : DEN_WIDTH'(trial[k][l]);
            assign w_next[k][l]   = {w_cur[k][l][NUM_WIDTH-2:0], ge[k][l]};
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign quot[l] = w_reg[NUM_WIDTH-1][l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_WIDTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < NUM_WIDTH; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < NUM_WIDTH; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                w_reg[k][l]   <= w_next[k][l];
                rem_reg[k][l] <= rem_next[k][l];
                den_reg[k][l] <= den_cur[k][l];
            end
        end
    end

    assign out_valid = valid_reg[NUM_WIDTH-1];
    assign out_side  = side_reg[NUM_WIDTH-1];

endmodule

/* sv/voxel_shape_distance_eval.sv */
// Inside-distance evaluator for an ellipsoid, a box or an elliptic cylinder
// centered at the origin. Pulse start with a Q11.4 point while busy is low;
// busy never rises, so a new point may be given in every cycle. Each point
// yields exactly one result, shown for a single cycle with done high;
// results leave in the order the points came and cannot be held off. The
// pipeline is built from the bit-serial stages: a 16-step root of the
// squared radius, a 31-step and a 30-step divider per axis to normalize and
// scale the direction, a 60-step reciprocal divider and a 30-step root, plus
// stages of multiply, add, select and saturation. Program shape and sizes
// over APB only while no point is in flight; the registers are read live by
// the stages that use them.
module voxel_shape_distance_eval
    import vsde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  point_t      point,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [59:0] RECIP_ONE = 60'(1) << 58;
    localparam int LATENCY = 4 + (32 + 1) / 2 + 1 + 1 + 31 + 1 + 30 + 3 + 60
                             + (59 + 1) / 2 + 1 + 2;

    cfg_t cfg;

    vsde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pipeline never stalls.
    assign busy = 1'b0;

    function automatic logic [SIZE_WIDTH-1:0] size_eff(input logic [SIZE_WIDTH-1:0] v);
        return (v == '0) ? SIZE_WIDTH'(1) : v;
    endfunction

    function automatic logic [MAG_WIDTH-1:0] mag16(input logic signed [COORD_WIDTH-1:0] v);
        return v[COORD_WIDTH-1] ? MAG_WIDTH'(-v) : MAG_WIDTH'(v);
    endfunction

    // Effective sizes: a zero size reads as one.
    logic [SIZE_WIDTH-1:0] size_v [3];
    logic [SIZE_WIDTH-1:0] size_max;

    assign size_v[0] = size_eff(cfg.half_size_x);
    assign size_v[1] = size_eff(cfg.half_size_y);
    assign size_v[2] = size_eff(cfg.half_size_z);

    always_comb
    begin
        size_max = size_v[0];
        if (size_v[1] > size_max)
        begin
            size_max = size_v[1];
        end
        if (size_v[2] > size_max)
        begin
            size_max = size_v[2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the point.
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    point_t s1_point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_point_reg <= point;
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes, box cube tests, cylinder cap distance.
    // ------------------------------------------------------------------
    logic signed [DIST_WIDTH-1:0] pe [3];
    logic signed [DIST_WIDTH-1:0] se [3];
    logic signed [DIST_WIDTH-1:0] sme;
    logic [MAG_WIDTH-1:0]         s2_mag [3];
    logic [2:0]                   outside_ax;
    logic [2:0]                   inside_ax;
    side_t                        s2_side;

    logic                 s2_valid_reg;
    logic [MAG_WIDTH-1:0] s2_mag_reg [3];
    side_t                s2_side_reg;

    assign pe[0] = DIST_WIDTH'(s1_point_reg.point_x);
    assign pe[1] = DIST_WIDTH'(s1_point_reg.point_y);
    assign pe[2] = DIST_WIDTH'(s1_point_reg.point_z);
    assign sme   = $signed({3'b000, cfg.smoothness});

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        assign se[i]         = $signed({3'b000, size_v[i]});
        assign outside_ax[i] = (pe[i] < -se[i] - sme) || (pe[i] >= se[i] + sme);
        assign inside_ax[i]  = (pe[i] >= sme - se[i]) && (pe[i] < se[i] - sme);
    end

    assign s2_mag[0] = mag16(s1_point_reg.point_x);
    assign s2_mag[1] = mag16(s1_point_reg.point_y);
    assign s2_mag[2] = mag16(s1_point_reg.point_z);

    always_comb
    begin
        s2_side          = '0;
        s2_side.is_box   = (cfg.shape_kind == SHAPE_BOX);
        s2_side.is_cyl   = (cfg.shape_kind == SHAPE_ECYL);
        s2_side.a_x      = s2_mag[0];
        s2_side.a_y      = s2_mag[1];
        // the cylinder's radial term spans x and y only
        s2_side.a_z      = s2_side.is_cyl ? '0 : s2_mag[2];
        s2_side.origin   = (s2_side.a_x == '0) && (s2_side.a_y == '0)
                           && (s2_side.a_z == '0);
        s2_side.rz       = se[2] - $signed({2'b00, s2_mag[2]});
        // only the box has the infinity classes
        if (s2_side.is_box && (outside_ax != 3'b000))
        begin
            s2_side.cls = CLASS_NEG_INF;
        end
        else if (s2_side.is_box && (inside_ax == 3'b111))
        begin
            s2_side.cls = CLASS_POS_INF;
        end
        else
        begin
            s2_side.cls = CLASS_FINITE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mag_reg  <= s2_mag;
        s2_side_reg <= s2_side;
    end

    // ------------------------------------------------------------------
    // Stage 3: squares for the radius, cross products for the box ratio.
    // ------------------------------------------------------------------
    logic          s3_valid_reg;
    logic [31:0]   s3_sq_reg [3];
    logic [30:0]   s3_p10_reg, s3_p01_reg, s3_p20_reg, s3_p02_reg, s3_p21_reg, s3_p12_reg;
    logic [MAG_WIDTH-1:0] s3_mag_reg [3];
    side_t         s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sq_reg[0] <= 32'(s2_side_reg.a_x) * 32'(s2_side_reg.a_x);
        s3_sq_reg[1] <= 32'(s2_side_reg.a_y) * 32'(s2_side_reg.a_y);
        s3_sq_reg[2] <= 32'(s2_side_reg.a_z) * 32'(s2_side_reg.a_z);
        s3_p10_reg   <= 31'(size_v[1]) * 31'(s2_mag_reg[0]);
        s3_p01_reg   <= 31'(size_v[0]) * 31'(s2_mag_reg[1]);
        s3_p20_reg   <= 31'(size_v[2]) * 31'(s2_mag_reg[0]);
        s3_p02_reg   <= 31'(size_v[0]) * 31'(s2_mag_reg[2]);
        s3_p21_reg   <= 31'(size_v[2]) * 31'(s2_mag_reg[1]);
        s3_p12_reg   <= 31'(size_v[1]) * 31'(s2_mag_reg[2]);
        s3_mag_reg   <= s2_mag_reg;
        s3_side_reg  <= s2_side_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: radius sum; box axis with the smallest size/|p| ratio,
    // ties keep the earlier axis.
    // ------------------------------------------------------------------
    logic [1:0]  best;
    logic        none;
    side_t       s4_side;

    logic        s4_valid_reg;
    logic [31:0] s4_sum_reg;
    side_t       s4_side_reg;

    always_comb
    begin
        best = AXIS_X;
        none = 1'b1;
        if (s3_mag_reg[0] != '0)
        begin
            best = AXIS_X;
            none = 1'b0;
        end
        if ((s3_mag_reg[1] != '0) && (none || (s3_p10_reg < s3_p01_reg)))
        begin
            best = AXIS_Y;
            none = 1'b0;
        end
        if (s3_mag_reg[2] != '0)
        begin
            if (none || ((best == AXIS_X) && (s3_p20_reg < s3_p02_reg))
                || ((best == AXIS_Y) && (s3_p21_reg < s3_p12_reg)))
            begin
                best = AXIS_Z;
                none = 1'b0;
            end
        end
    end

    always_comb
    begin
        s4_side = s3_side_reg;
        if (s3_side_reg.is_box && (s3_side_reg.cls == CLASS_FINITE))
        begin
            if (none)
            begin
                // box at the origin: fully inside
                s4_side.cls = CLASS_POS_INF;
            end
            else
            begin
                case (best)
                    AXIS_Y:  s4_side.box_dist = $signed({3'b000, size_v[1]})
                                                - $signed({2'b00, s3_mag_reg[1]});
                    AXIS_Z:  s4_side.box_dist = $signed({3'b000, size_v[2]})
                                                - $signed({2'b00, s3_mag_reg[2]});
                    default: s4_side.box_dist = $signed({3'b000, size_v[0]})
                                                - $signed({2'b00, s3_mag_reg[0]});
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sum_reg  <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];
        s4_side_reg <= s4_side;
    end

    // ------------------------------------------------------------------
    // d = round(sqrt(D))
    // ------------------------------------------------------------------
    logic        sq1_valid;
    logic [16:0] sq1_root;
    side_t       sq1_side;

    vsde_sqrt #(
        .IN_WIDTH (32)
    ) u_sqrt_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .radicand  (s4_sum_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq1_valid),
        .root      (sq1_root),
        .out_side  (sq1_side)
    );

    // ------------------------------------------------------------------
    // Prep: c_i = round(a_i * 2^15 / d)
    // ------------------------------------------------------------------
    side_t       p1_side_in;
    logic        p1_valid_reg;
    logic [30:0] p1_num_reg [3];
    logic [16:0] p1_den_reg [3];
    side_t       p1_side_reg;

    always_comb
    begin
        p1_side_in   = sq1_side;
        p1_side_in.d = sq1_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= sq1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_num_reg[0]   <= {sq1_side.a_x, 15'd0} + 31'(sq1_root >> 1);
        p1_num_reg[1]   <= {sq1_side.a_y, 15'd0} + 31'(sq1_root >> 1);
        p1_num_reg[2]   <= {sq1_side.a_z, 15'd0} + 31'(sq1_root >> 1);
        p1_den_reg[0]   <= sq1_root;
        p1_den_reg[1]   <= sq1_root;
        p1_den_reg[2]   <= sq1_root;
        p1_side_reg     <= p1_side_in;
    end

    logic        dv1_valid;
    logic [30:0] dv1_quot [3];
    side_t       dv1_side;

    vsde_div #(
        .NUM_WIDTH (31),
        .DEN_WIDTH (17),
        .LANES     (3)
    ) u_div_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .numer     (p1_num_reg),
        .denom     (p1_den_reg),
        .in_side   (p1_side_reg),
        .out_valid (dv1_valid),
        .quot      (dv1_quot),
        .out_side  (dv1_side)
    );

    // ------------------------------------------------------------------
    // Prep: t_i = round(c_i * 2^14 / s_i)
    // ------------------------------------------------------------------
    logic        p2_valid_reg;
    logic [29:0] p2_num_reg [3];
    logic [14:0] p2_den_reg [3];
    side_t       p2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= dv1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2_num_reg[i] <= {dv1_quot[i][15:0], 14'd0} + 30'(size_v[i] >> 1);
            p2_den_reg[i] <= size_v[i];
        end
        p2_side_reg <= dv1_side;
    end

    logic        dv2_valid;
    logic [29:0] dv2_quot [3];
    side_t       dv2_side;

    vsde_div #(
        .NUM_WIDTH (30),
        .DEN_WIDTH (15),
        .LANES     (3)
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .numer     (p2_num_reg),
        .denom     (p2_den_reg),
        .in_side   (p2_side_reg),
        .out_valid (dv2_valid),
        .quot      (dv2_quot),
        .out_side  (dv2_side)
    );

    // ------------------------------------------------------------------
    // Square t_i, sum to T, form round(2^58 / T) operands.
    // ------------------------------------------------------------------
    logic        q_valid_reg;
    logic [59:0] q_sq_reg [3];
    side_t       q_side_reg;

    side_t       t_side_in;
    logic        t_valid_reg;
    logic [59:0] t_sum_reg;
    side_t       t_side_reg;

    logic        p3_valid_reg;
    logic [59:0] p3_num_reg [1];
    logic [59:0] p3_den_reg [1];
    side_t       p3_side_reg;

    always_comb
    begin
        t_side_in        = q_side_reg;
        t_side_in.t_zero = (q_sq_reg[0] == '0) && (q_sq_reg[1] == '0)
                           && (q_sq_reg[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg  <= 1'b0;
            t_valid_reg  <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg  <= dv2_valid;
            t_valid_reg  <= q_valid_reg;
            p3_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_sq_reg[i] <= 60'(dv2_quot[i]) * 60'(dv2_quot[i]);
        end
        q_side_reg <= dv2_side;

        t_sum_reg  <= q_sq_reg[0] + q_sq_reg[1] + q_sq_reg[2];
        t_side_reg <= t_side_in;

        p3_num_reg[0] <= RECIP_ONE + (t_sum_reg >> 1);
        p3_den_reg[0] <= t_sum_reg;
        p3_side_reg   <= t_side_reg;
    end

    logic        dv3_valid;
    logic [59:0] dv3_quot [1];
    side_t       dv3_side;

    vsde_div #(
        .NUM_WIDTH (60),
        .DEN_WIDTH (60),
        .LANES     (1)
    ) u_div_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .numer     (p3_num_reg),
        .denom     (p3_den_reg),
        .in_side   (p3_side_reg),
        .out_valid (dv3_valid),
        .quot      (dv3_quot),
        .out_side  (dv3_side)
    );

    // ------------------------------------------------------------------
    // r = round(sqrt(round(2^58 / T)))
    // ------------------------------------------------------------------
    logic        sq2_valid;
    logic [29:0] sq2_root;
    side_t       sq2_side;

    vsde_sqrt #(
        .IN_WIDTH (59)
    ) u_sqrt_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv3_valid),
        .radicand  (dv3_quot[0][58:0]),
        .in_side   (dv3_side),
        .out_valid (sq2_valid),
        .root      (sq2_root),
        .out_side  (sq2_side)
    );

    // ------------------------------------------------------------------
    // Final 1: radial distance r - d; the origin and a zero T take the
    // largest half-size as r.
    // ------------------------------------------------------------------
    logic [29:0]         r_sel;
    logic                f1_valid_reg;
    logic signed [32:0]  f1_rr_reg;
    side_t               f1_side_reg;

    assign r_sel = (sq2_side.origin || sq2_side.t_zero) ? 30'(size_max) : sq2_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= sq2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_rr_reg   <= $signed({3'b000, r_sel}) - $signed({16'd0, sq2_side.d});
        f1_side_reg <= sq2_side;
    end

    // ------------------------------------------------------------------
    // Final 2: pick per shape, cylinder cap, saturate, present for a cycle.
    // ------------------------------------------------------------------
    logic signed [32:0] box_wide;
    logic signed [32:0] rz_wide;
    logic signed [32:0] sel;
    result_t            result_next;

    logic    done_reg;
    result_t result_reg;

    assign box_wide = 33'(f1_side_reg.box_dist);
    assign rz_wide  = 33'(f1_side_reg.rz);

    always_comb
    begin
        if (f1_side_reg.is_box)
        begin
            sel = box_wide;
        end
        else if (f1_side_reg.is_cyl)
        begin
            sel = (rz_wide < f1_rr_reg) ? rz_wide : f1_rr_reg;
        end
        else
        begin
            sel = f1_rr_reg;
        end

        result_next.result_class = f1_side_reg.cls;
        if (f1_side_reg.cls != CLASS_FINITE)
        begin
            result_next.distance = '0;
        end
        else if (sel > 33'sd131071)
        begin
            result_next.distance = 18'sh1FFFF;
        end
        else if (sel < -33'sd131072)
        begin
            result_next.distance = 18'sh20000;
        end
        else
        begin
            result_next.distance = sel[DIST_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing at fixed latency");

    a_infinite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.result_class != CLASS_FINITE) |-> result.distance == '0)
        else $error("non-finite class carries a nonzero distance");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(f1_valid_reg))
        else $error("result strobe without an item in the last stage");

endmodule
